// ===== hw/rtl/pisd_pkg.sv =====
// ============================================================================
// pisd_pkg - shared types and constants for the palette image stream decoder
// Beat layouts, queue op format, result kinds and error codes.
// ============================================================================
package pisd_pkg;

    // Default size of the index plane store, in pixels
    localparam int DEF_MAX_PIXELS  = 65536;
    localparam int PALETTE_ENTRIES = 256;

    // File layout
    localparam int HEADER_BYTES  = 156;
    localparam int PALETTE_BYTES = PALETTE_ENTRIES * 4;
    localparam int POS_W         = $clog2(PALETTE_BYTES);

    localparam logic [31:0] IDENT_WORD = 32'h3150_4C42;  // "BLP1" little-endian

    // Header word slots (byte position / 4)
    localparam logic [7:0] WORD_IDENT       = 8'd0;
    localparam logic [7:0] WORD_COMPRESSION = 8'd1;
    localparam logic [7:0] WORD_WIDTH       = 8'd3;
    localparam logic [7:0] WORD_HEIGHT      = 8'd4;
    localparam logic [7:0] WORD_TYPE        = 8'd5;
    localparam logic [7:0] WORD_SUBTYPE     = 8'd6;

    localparam logic [31:0] COMP_JPEG    = 32'd0;
    localparam logic [31:0] COMP_PALETTE = 32'd1;

    localparam logic [31:0] PIC_TYPE_ALPHA_A = 32'd3;
    localparam logic [31:0] PIC_TYPE_ALPHA_B = 32'd4;
    localparam logic [31:0] PIC_TYPE_DIRECT  = 32'd5;

    // Depth of the queue between parser and executor
    localparam int QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_IDENT     = 3'd1;
    localparam logic [2:0] ERR_JPEG      = 3'd2;
    localparam logic [2:0] ERR_TYPE      = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_pixel;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [31:0] picture_type;
        logic [31:0] picture_subtype;
        logic [2:0]  error_code;
    } t_out_beat;

    // Ops handed from the parser to the executor
    typedef enum logic [2:0] {
        OP_PAL_WR,      // write palette entry byte_val with word
        OP_IDX_WR,      // write index store at address with byte_val
        OP_HEADER,      // emit header result
        OP_ERROR,       // emit error result
        OP_PIX_DIRECT,  // pixel from palette[byte_val], inverted palette alpha
        OP_PIX_PLANE    // pixel from palette[index_store[address]], alpha byte_val
    } t_op_code;

    typedef struct packed {
        t_op_code    code;
        logic [7:0]  byte_val;
        logic [31:0] word;
        logic        last;
        logic [2:0]  err;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] ptype;
        logic [31:0] psubtype;
    } t_op;

endpackage

// ===== hw/rtl/pisd_front.sv =====
// ============================================================================
// pisd_front - byte parser
// Tracks the file layout, checks the header and turns the file's bytes into
// ops for the executor queue.
// ============================================================================
module pisd_front
    import pisd_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_in_beat                      i_data,
    input  logic                          i_full,
    output logic                          o_push,
    output t_op                           o_op,
    output logic [$clog2(MAX_PIXELS)-1:0] o_addr
);

    localparam int IDX_W = $clog2(MAX_PIXELS);
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PALETTE,
        PH_DIRECT,
        PH_PLANE,
        PH_ALPHA,
        PH_DONE
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [31:0]        r_word, n_word;
    logic               r_wide, n_wide;
    logic [15:0]        r_width, n_width;
    logic [15:0]        r_height, n_height;
    logic [31:0]        r_comp, n_comp;
    logic [31:0]        r_type, n_type;
    logic [31:0]        r_subtype, n_subtype;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [31:0]        r_prod;

    logic               accept;
    t_phase             eff_phase;
    logic [POS_W-1:0]   eff_pos;
    logic [31:0]        eff_word;
    logic               eff_wide;
    logic [1:0]         lane;
    logic [31:0]        full_word;
    logic [CNT_W-1:0]   cnt_inc;
    logic               push_req;

    assign accept = i_valid && !i_full;
    assign o_push = accept && push_req;

    // pixel count, registered ahead of the header end
    always_ff @(posedge i_clk) begin
        r_prod <= 32'(r_width) * 32'(r_height);
    end

    // file_start restarts the parser on this very byte
    always_comb begin
        eff_phase = i_data.file_start ? PH_HEADER : r_phase;
        eff_pos   = i_data.file_start ? '0 : r_pos;
        eff_word  = i_data.file_start ? '0 : r_word;
        eff_wide  = i_data.file_start ? 1'b0 : r_wide;
    end

    assign lane      = eff_pos[1:0];
    assign full_word = {i_data.data_byte, eff_word[23:0]};
    assign cnt_inc   = r_cnt + CNT_W'(1);

    // parse step
    always_comb begin
        n_phase   = eff_phase;
        n_pos     = eff_pos;
        n_word    = eff_word;
        n_wide    = eff_wide;
        n_width   = r_width;
        n_height  = r_height;
        n_comp    = r_comp;
        n_type    = r_type;
        n_subtype = r_subtype;
        n_total   = r_total;
        n_cnt     = r_cnt;
        push_req  = 1'b0;
        o_op      = '0;
        o_addr    = '0;

        case (eff_phase)
            PH_HEADER: begin
                n_pos = eff_pos + POS_W'(1);
                if (lane == 2'd3) begin
                    n_word = '0;
                    case (8'(eff_pos[POS_W-1:2]))
                        WORD_IDENT: begin
                            if (full_word != IDENT_WORD) begin
                                push_req  = 1'b1;
                                o_op.code = OP_ERROR;
                                o_op.err  = ERR_IDENT;
                                n_phase   = PH_IDLE;
                            end
                        end
                        WORD_COMPRESSION: n_comp = full_word;
                        WORD_WIDTH: begin
                            n_width = full_word[15:0];
                            if (full_word[31:16] != 16'd0) n_wide = 1'b1;
                        end
                        WORD_HEIGHT: begin
                            n_height = full_word[15:0];
                            if (full_word[31:16] != 16'd0) n_wide = 1'b1;
                        end
                        WORD_TYPE:    n_type    = full_word;
                        WORD_SUBTYPE: n_subtype = full_word;
                        default: ;
                    endcase
                end else begin
                    n_word = eff_word | (32'(i_data.data_byte) << {lane, 3'b000});
                end
                // header end checks
                if (eff_pos == POS_W'(HEADER_BYTES - 1)) begin
                    push_req = 1'b1;
                    if (r_comp == COMP_JPEG) begin
                        o_op.code = OP_ERROR;
                        o_op.err  = ERR_JPEG;
                        n_phase   = PH_IDLE;
                    end else if (r_comp != COMP_PALETTE ||
                                 !(r_type inside {PIC_TYPE_ALPHA_A, PIC_TYPE_ALPHA_B,
                                                  PIC_TYPE_DIRECT})) begin
                        o_op.code = OP_ERROR;
                        o_op.err  = ERR_TYPE;
                        n_phase   = PH_IDLE;
                    end else if (r_wide || r_prod > 32'(MAX_PIXELS)) begin
                        o_op.code = OP_ERROR;
                        o_op.err  = ERR_TOO_LARGE;
                        n_phase   = PH_IDLE;
                    end else begin
                        o_op.code     = OP_HEADER;
                        o_op.width    = r_width;
                        o_op.height   = r_height;
                        o_op.ptype    = r_type;
                        o_op.psubtype = r_subtype;
                        n_total       = r_prod[CNT_W-1:0];
                        n_phase       = PH_PALETTE;
                        n_pos         = '0;
                        n_word        = '0;
                    end
                end
            end
            PH_PALETTE: begin
                n_pos = eff_pos + POS_W'(1);
                if (lane == 2'd3) begin
                    push_req      = 1'b1;
                    o_op.code     = OP_PAL_WR;
                    o_op.byte_val = 8'(eff_pos[POS_W-1:2]);
                    o_op.word     = full_word;
                    n_word        = '0;
                end else begin
                    n_word = eff_word | (32'(i_data.data_byte) << {lane, 3'b000});
                end
                if (eff_pos == POS_W'(PALETTE_BYTES - 1)) begin
                    n_cnt = '0;
                    if (r_total == '0) begin
                        n_phase = PH_DONE;
                    end else if (r_type == PIC_TYPE_DIRECT) begin
                        n_phase = PH_DIRECT;
                    end else begin
                        n_phase = PH_PLANE;
                    end
                end
            end
            PH_DIRECT: begin
                push_req      = 1'b1;
                o_op.code     = OP_PIX_DIRECT;
                o_op.byte_val = i_data.data_byte;
                o_op.last     = cnt_inc >= r_total;
                n_cnt         = cnt_inc;
                if (cnt_inc >= r_total) n_phase = PH_DONE;
            end
            PH_PLANE: begin
                push_req      = 1'b1;
                o_op.code     = OP_IDX_WR;
                o_op.byte_val = i_data.data_byte;
                o_addr        = r_cnt[IDX_W-1:0];
                if (cnt_inc >= r_total) begin
                    n_cnt   = '0;
                    n_phase = PH_ALPHA;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_ALPHA: begin
                push_req      = 1'b1;
                o_op.code     = OP_PIX_PLANE;
                o_op.byte_val = i_data.data_byte;
                o_op.last     = cnt_inc >= r_total;
                o_addr        = r_cnt[IDX_W-1:0];
                n_cnt         = cnt_inc;
                if (cnt_inc >= r_total) n_phase = PH_DONE;
            end
            default: ;
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_word    <= '0;
            r_wide    <= 1'b0;
            r_width   <= '0;
            r_height  <= '0;
            r_comp    <= '0;
            r_type    <= '0;
            r_subtype <= '0;
            r_total   <= '0;
            r_cnt     <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_word    <= n_word;
            r_wide    <= n_wide;
            r_width   <= n_width;
            r_height  <= n_height;
            r_comp    <= n_comp;
            r_type    <= n_type;
            r_subtype <= n_subtype;
            r_total   <= n_total;
            r_cnt     <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/pisd_fifo.sv =====
// ============================================================================
// pisd_fifo - op queue between parser and executor
// Small register queue; full and valid come straight from registers.
// ============================================================================
module pisd_fifo
    import pisd_pkg::*;
#(
    parameter int WIDTH = $bits(t_op)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_data;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/pisd_back.sv =====
// ============================================================================
// pisd_back - op executor
// Owns the palette and index stores, runs the two reads of a pixel through a
// short pipeline and holds the result beat in the output register.
// ============================================================================
module pisd_back
    import pisd_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_head_valid,
    input  logic [$clog2(MAX_PIXELS)+$bits(t_op)-1:0] i_head,
    output logic                                  o_pop,
    output logic                                  o_valid,
    output t_out_beat                             o_data,
    input  logic                                  i_stall
);

    localparam int IDX_W = $clog2(MAX_PIXELS);

    logic [7:0]       r_index_mem [MAX_PIXELS];
    logic [31:0]      r_pal_mem [PALETTE_ENTRIES];

    t_op              head_op;
    logic [IDX_W-1:0] head_addr;
    logic             adv;
    logic [7:0]       pal_addr;
    t_out_beat        n_out;

    logic             r_s1_valid;
    t_op              r_s1_op;
    logic [7:0]       r_idx_rd;
    logic             r_s2_valid;
    t_op              r_s2_op;
    logic [31:0]      r_pal_rd;
    logic             r_out_valid;
    t_out_beat        r_out;

    assign {head_addr, head_op} = i_head;

    // whole pipeline moves when the output register is free or being taken
    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && i_head_valid;

    assign pal_addr = (r_s1_op.code == OP_PIX_DIRECT) ? r_s1_op.byte_val : r_idx_rd;

    // index store: written on pop, read for the op being popped
    always_ff @(posedge i_clk) begin
        if (o_pop && head_op.code == OP_IDX_WR) r_index_mem[head_addr] <= head_op.byte_val;
        if (adv) r_idx_rd <= r_index_mem[head_addr];
    end

    // palette store: written on pop, read one stage later
    always_ff @(posedge i_clk) begin
        if (o_pop && head_op.code == OP_PAL_WR) r_pal_mem[head_op.byte_val] <= head_op.word;
        if (adv) r_pal_rd <= r_pal_mem[pal_addr];
    end

    // result beat assembly
    always_comb begin
        n_out = '0;
        case (r_s2_op.code)
            OP_HEADER: begin
                n_out.kind            = KIND_HEADER;
                n_out.image_width     = r_s2_op.width;
                n_out.image_height    = r_s2_op.height;
                n_out.picture_type    = r_s2_op.ptype;
                n_out.picture_subtype = r_s2_op.psubtype;
            end
            OP_ERROR: begin
                n_out.kind       = KIND_ERROR;
                n_out.error_code = r_s2_op.err;
            end
            OP_PIX_DIRECT: begin
                n_out.kind       = KIND_PIXEL;
                n_out.red        = r_pal_rd[7:0];
                n_out.green      = r_pal_rd[15:8];
                n_out.blue       = r_pal_rd[23:16];
                n_out.alpha      = ~r_pal_rd[31:24];
                n_out.last_pixel = r_s2_op.last;
            end
            OP_PIX_PLANE: begin
                n_out.kind       = KIND_PIXEL;
                n_out.red        = r_pal_rd[7:0];
                n_out.green      = r_pal_rd[15:8];
                n_out.blue       = r_pal_rd[23:16];
                n_out.alpha      = r_s2_op.byte_val;
                n_out.last_pixel = r_s2_op.last;
            end
            default: ;
        endcase
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_op.code != OP_PAL_WR &&
                           r_s2_op.code != OP_IDX_WR;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op <= head_op;
            r_s2_op <= r_s1_op;
            r_out   <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/palette_image_stream_decoder_core.sv =====
// ============================================================================
// palette_image_stream_decoder_core - palettized image file decoder
// Parses an uncompressed palette image file byte by byte and streams pixels.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall / i_data) carries one file byte per beat;
//   file_start marks byte 0 of a file and restarts the parser at any time.
//   Output channel (o_valid / i_stall / o_data) carries one result per beat:
//   a header beat after the 156-byte header, then one pixel beat per index
//   byte (direct type) or per alpha-plane byte (alpha-plane types), or a
//   single error beat, after which bytes are ignored until the next file.
//   Throughput is one byte per cycle while the output is not stalled; the parser
//   and the executor each take a byte/op every cycle, tied by a four-entry op queue.
//   An accepted byte reaches its result beat through the queue, the index
//   store read, the palette read and the output register.
//   When the receiver stalls, the executor holds and the queue fills; o_stall
//   rises once four ops are waiting.
//   Reset (synchronous, active low) empties the queue and pipeline and puts
//   the parser in idle, waiting for a file start. The stores need no clear:
//   each file writes them before reading them.
// ============================================================================
module palette_image_stream_decoder_core
    import pisd_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    localparam int IDX_W = $clog2(MAX_PIXELS);
    localparam int ENT_W = IDX_W + $bits(t_op);

    logic             q_full;
    logic             q_push;
    t_op              push_op;
    logic [IDX_W-1:0] push_addr;
    logic             q_valid;
    logic [ENT_W-1:0] q_head;
    logic             q_pop;

    assign o_stall = q_full;

    // parser
    pisd_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_op    (push_op),
        .o_addr  (push_addr)
    );

    // op queue
    pisd_fifo #(
        .WIDTH (ENT_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data ({push_addr, push_op}),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_head),
        .i_pop       (q_pop)
    );

    // executor
    pisd_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .i_stall      (i_stall)
    );

endmodule
